@@ hw/rtl/pwsc_pkg.sv @@
// ----------------------------------------------------------------------------
// Pulse width sorter counter package
// Shared widths, codes and item types of the sorter/counter block.
// ----------------------------------------------------------------------------
package pwsc_pkg;

  // Item counter width (8 to 32)
  localparam int CNT_W = 16;

  // Width arithmetic: tally (8) x modulo (16), then a signed width word
  localparam int TALLY_W = 8;
  localparam int PROD_W  = 24;
  localparam int WID_W   = 26;

  // Percentage divider: dividend is defective * 100
  localparam int PCT_SCALE  = 100;
  localparam int DIV_W      = CNT_W + 7;
  localparam int DIV_CNT_W  = $clog2(DIV_W);

  // Configuration reset values
  localparam logic [23:0]        MIN_WIDTH_RST  = 24'd30000;
  localparam logic [23:0]        MAX_WIDTH_RST  = 24'd50000;
  localparam logic [15:0]        MODULO_RST     = 16'd30000;
  localparam logic [TALLY_W-1:0] TLIMIT_RST     = 8'd2;
  localparam logic [TALLY_W-1:0] TALLY_MAX      = 8'd255;

  // Item commands
  typedef enum logic [2:0] {
    CMD_EDGE    = 3'd0,
    CMD_RUNSTOP = 3'd1,
    CMD_CLEAR   = 3'd2,
    CMD_SHOWSTD = 3'd3,
    CMD_SHOWOVR = 3'd4,
    CMD_SHOWUND = 3'd5,
    CMD_PERCENT = 3'd6,
    CMD_TICK    = 3'd7
  } cmd_e;

  // Message kinds
  typedef enum logic [2:0] {
    MSG_NONE    = 3'd0,
    MSG_STD     = 3'd1,
    MSG_OVER    = 3'd2,
    MSG_UNDER   = 3'd3,
    MSG_PERCENT = 3'd4,
    MSG_TIMEOUT = 3'd5
  } msg_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_MIN_WIDTH = 2'd0,
    REG_MAX_WIDTH = 2'd1,
    REG_MODULO    = 2'd2,
    REG_TLIMIT    = 2'd3
  } cfg_reg_e;

  // Input item
  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] capture_value;
  } in_t;

  // Result item
  typedef struct packed {
    logic        belt_on;
    logic        sensor_led;
    logic        passed_led;
    logic        defect_led;
    logic [2:0]  msg_kind;
    logic [15:0] shown_value;
    logic        timed_out;
  } out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_item;
    logic exec;
    logic mul;
    logic meas;
    logic div_init;
    logic div_step;
    logic pct;
    logic load_out;
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic [2:0] cmd;
    logic       running;
    logic       awaiting;
    logic       total_zero;
    logic       div_last;
  } stat_t;

endpackage

@@ hw/rtl/pwsc_div.sv @@
// ----------------------------------------------------------------------------
// Percentage divider
// Restoring divider, one quotient bit per cycle while step is high.
// ----------------------------------------------------------------------------
module pwsc_div
  import pwsc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             step,
  input  logic [DIV_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [DIV_W-1:0] quotient,
  output logic             last
);

  logic [CNT_W-1:0]     rem_r;
  logic [DIV_W-1:0]     quo_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [CNT_W:0]       rem_sh;
  logic [CNT_W:0]       rem_sub;
  logic                 ge;

  // trial subtract of the shifted remainder
  always_comb begin
    rem_sh  = {rem_r, quo_r[DIV_W-1]};
    ge      = rem_sh >= {1'b0, divisor};
    rem_sub = rem_sh - {1'b0, divisor};
  end

  // remainder and quotient shift registers
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
    end else if (step) begin
      rem_r <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
      quo_r <= {quo_r[DIV_W-2:0], ge};
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= DIV_CNT_W'(DIV_W - 1);
    end else if (step && cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign quotient = quo_r;
  assign last     = (cnt_r == '0);

endmodule

@@ hw/rtl/pwsc_datapath.sv @@
// ----------------------------------------------------------------------------
// Sorter datapath
// Configuration, belt state, counters, width arithmetic and result registers.
// ----------------------------------------------------------------------------
module pwsc_datapath
  import pwsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  in_t         in_data,
  input  ctl_t        ctl,
  output stat_t       stat,
  output out_t        out_data
);

  // configuration
  logic [23:0]        min_w_r;
  logic [23:0]        max_w_r;
  logic [15:0]        mod_r;
  logic [TALLY_W-1:0] tlim_r;

  // belt state and counters
  logic               running_r, running_nxt;
  logic               await_r, await_nxt;
  logic [15:0]        first_r, first_nxt;
  logic [TALLY_W-1:0] tally_r, tally_nxt;
  logic [CNT_W-1:0]   total_r, total_nxt;
  logic [CNT_W-1:0]   std_r, std_nxt;
  logic [CNT_W-1:0]   over_r, over_nxt;
  logic [CNT_W-1:0]   under_r, under_nxt;
  logic [CNT_W-1:0]   def_r, def_nxt;
  logic [2:0]         led_r, led_nxt;

  // payload
  in_t                item_r;
  logic [PROD_W-1:0]  prod_r;
  out_t               res_r, res_nxt;
  out_t               out_r;

  logic [PROD_W-1:0]  prod_c;
  logic [WID_W-1:0]   width_c;
  logic               neg_c, is_std, is_over;
  logic [TALLY_W-1:0] tally_inc;
  logic [DIV_W-1:0]   dividend_c;
  logic [DIV_W-1:0]   quo;
  logic               div_last;
  logic               sat;
  logic [2:0]         kind;
  logic [15:0]        shown;
  logic               tout;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_w_r <= MIN_WIDTH_RST;
      max_w_r <= MAX_WIDTH_RST;
      mod_r   <= MODULO_RST;
      tlim_r  <= TLIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_WIDTH: min_w_r <= cfg_wdata;
        REG_MAX_WIDTH: max_w_r <= cfg_wdata;
        REG_MODULO:    mod_r   <= cfg_wdata[15:0];
        REG_TLIMIT:    tlim_r  <= cfg_wdata[TALLY_W-1:0];
        default: ;
      endcase
    end
  end

  // overflow periods in timer counts
  assign prod_c = {16'b0, tally_r} * {8'b0, mod_r};

  // width = capture + tally * modulo - first capture, signed
  always_comb begin
    width_c = WID_W'(item_r.capture_value) + WID_W'(prod_r) - WID_W'(first_r);
    neg_c   = width_c[WID_W-1];
    is_std  = !neg_c && (width_c >= WID_W'(min_w_r)) && (width_c <= WID_W'(max_w_r));
    is_over = !neg_c && (width_c > WID_W'(max_w_r));
  end

  assign tally_inc  = (tally_r == TALLY_MAX) ? TALLY_MAX : tally_r + 1'b1;
  assign dividend_c = DIV_W'(def_r) * DIV_W'(PCT_SCALE);
  assign sat        = (DIV_W > 16) && ((quo >> 16) != '0);

  pwsc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (ctl.div_init),
    .step     (ctl.div_step),
    .dividend (dividend_c),
    .divisor  (total_r),
    .quotient (quo),
    .last     (div_last)
  );

  // next state and result of the current step
  always_comb begin
    running_nxt = running_r;
    await_nxt   = await_r;
    first_nxt   = first_r;
    tally_nxt   = tally_r;
    total_nxt   = total_r;
    std_nxt     = std_r;
    over_nxt    = over_r;
    under_nxt   = under_r;
    def_nxt     = def_r;
    led_nxt     = led_r;
    kind        = MSG_NONE;
    shown       = '0;
    tout        = 1'b0;
    res_nxt     = res_r;

    if (ctl.exec) begin
      unique case (item_r.cmd)
        CMD_EDGE: begin
          // first edge of a pulse; the second goes through the measure path
          if (running_r && !await_r) begin
            tally_nxt = '0;
            await_nxt = 1'b1;
            first_nxt = item_r.capture_value;
            led_nxt   = {led_r[2], 2'b01};
          end
        end
        CMD_RUNSTOP: begin
          running_nxt = !running_r;
          if (running_r) led_nxt = '0;
        end
        CMD_CLEAR: begin
          if (!running_r) total_nxt = '0;
        end
        CMD_SHOWSTD: begin
          kind  = MSG_STD;
          shown = 16'(std_r);
        end
        CMD_SHOWOVR: begin
          kind  = MSG_OVER;
          shown = 16'(over_r);
        end
        CMD_SHOWUND: begin
          kind  = MSG_UNDER;
          shown = 16'(under_r);
        end
        CMD_PERCENT: begin
          // zero total only; otherwise the divider path
          kind  = MSG_PERCENT;
          shown = '0;
        end
        CMD_TICK: begin
          tally_nxt = tally_inc;
          if (tally_inc > tlim_r) begin
            tally_nxt   = '0;
            running_nxt = 1'b0;
            led_nxt     = '0;
            kind        = MSG_TIMEOUT;
            tout        = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // second edge: classify and count
    if (ctl.meas) begin
      await_nxt = 1'b0;
      tally_nxt = '0;
      total_nxt = total_r + 1'b1;
      if (is_std) begin
        std_nxt = std_r + 1'b1;
        kind    = MSG_STD;
        shown   = 16'(std_nxt);
        led_nxt = 3'b010;
      end else begin
        def_nxt = def_r + 1'b1;
        led_nxt = 3'b110;
        if (is_over) over_nxt  = over_r + 1'b1;
        else         under_nxt = under_r + 1'b1;
      end
    end

    // defect percentage, saturated
    if (ctl.pct) begin
      kind  = MSG_PERCENT;
      shown = sat ? 16'hFFFF : 16'(quo);
    end

    if (ctl.exec || ctl.meas || ctl.pct) begin
      res_nxt = '{belt_on:     running_nxt,
                  sensor_led:  led_nxt[0],
                  passed_led:  led_nxt[1],
                  defect_led:  led_nxt[2],
                  msg_kind:    kind,
                  shown_value: shown,
                  timed_out:   tout};
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      await_r   <= 1'b0;
      first_r   <= '0;
      tally_r   <= '0;
      total_r   <= '0;
      std_r     <= '0;
      over_r    <= '0;
      under_r   <= '0;
      def_r     <= '0;
      led_r     <= '0;
    end else begin
      running_r <= running_nxt;
      await_r   <= await_nxt;
      first_r   <= first_nxt;
      tally_r   <= tally_nxt;
      total_r   <= total_nxt;
      std_r     <= std_nxt;
      over_r    <= over_nxt;
      under_r   <= under_nxt;
      def_r     <= def_nxt;
      led_r     <= led_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (ctl.load_item) item_r <= in_data;
    if (ctl.mul)       prod_r <= prod_c;
    res_r <= res_nxt;
    if (ctl.load_out)  out_r  <= res_r;
  end

  assign stat = '{cmd:        item_r.cmd,
                  running:    running_r,
                  awaiting:   await_r,
                  total_zero: (total_r == '0),
                  div_last:   div_last};

  assign out_data = out_r;

  // defective count always tracks over plus under
  a_def_sum: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(over_r + under_r) == def_r)
    else $error("defective count out of step with over and under");

  // a stopped belt shows no LEDs
  a_led_stop: assert property (@(posedge clk) disable iff (!rst_n)
    !running_r |-> led_r == '0)
    else $error("LED lit while belt stopped");

  // a timeout result always reports a stopped belt
  a_tout: assert property (@(posedge clk) disable iff (!rst_n)
    $past(ctl.exec) && res_r.timed_out |->
      !res_r.belt_on && res_r.msg_kind == MSG_TIMEOUT)
    else $error("timeout result inconsistent");

endmodule

@@ hw/rtl/pwsc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sorter controller
// Sequences one item at a time and owns both handshakes.
// ----------------------------------------------------------------------------
module pwsc_ctrl
  import pwsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output ctl_t  ctl
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_DEC  = 7'b0000010,
    S_MUL  = 7'b0000100,
    S_MEAS = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_PCT  = 7'b0100000,
    S_OUT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_ready;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load_item = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        if (stat.cmd == CMD_EDGE && stat.running && stat.awaiting) begin
          ctl.mul   = 1'b1;
          state_nxt = S_MUL;
        end else if (stat.cmd == CMD_PERCENT && !stat.total_zero) begin
          ctl.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          ctl.exec  = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_MUL: begin
        state_nxt = S_MEAS;
      end
      S_MEAS: begin
        ctl.meas  = 1'b1;
        state_nxt = S_OUT;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_PCT;
      end
      S_PCT: begin
        ctl.pct   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          ctl.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ready)    out_valid_nxt = 1'b0;
    if (ctl.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // an accepted item is decoded next
  a_acc_dec: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DEC)
    else $error("accepted item not decoded");

  // a new result only appears from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.load_out |=> out_valid_r && $past(state_r) == S_OUT)
    else $error("result loaded outside output state");

  // a waiting result is never overwritten
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !ctl.load_out)
    else $error("pending result overwritten");

endmodule

@@ hw/rtl/pulse_width_sorter_counter_top.sv @@
// ----------------------------------------------------------------------------
// Pulse width sorter counter
// Conveyor item sorter: pairs sensor edges, measures pulse widths, keeps
// counts and reports the defect percentage and overflow timeouts.
//
//   channel  ports                              direction
//   in       in_valid, in_ready, in_data        item in (cmd, capture_value)
//   out      out_valid, out_ready, out_data     one result per item
//   cfg      cfg_we, cfg_addr, cfg_wdata        register write, no wait
//
// Buttons, first edges and ticks pass through the decode and output states; an
// edge that closes a pulse also passes the multiply and measure states (tally x
// modulo product, then classify). A defect percentage of a nonzero total runs
// the bit-serial divider in the divide state, then the percentage and output
// states. The output register frees the input side: a stalled result holds back
// only the item after it, in its final state.
// Reset is synchronous and active low; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pulse_width_sorter_counter_top
  import pwsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [23:0] cfg_wdata
);

  ctl_t  ctl;
  stat_t stat;

  pwsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  pwsc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .ctl       (ctl),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// Pulse width sorter counter testbench
// Drives command items (edges, buttons, ticks) through the valid/ready input,
// predicts each result from a behavioural copy of the belt and counter state,
// and checks every result field. Sender bursts, receiver stall patterns and
// register settings are varied across phases.
// ----------------------------------------------------------------------------
module tb;
  import pwsc_pkg::*;

  localparam int SETTLE   = 2 * (CNT_W + 11);  // percentage divide, twice over
  localparam int HOLD_LEN = 400;               // long receiver hold-off
  localparam int STALL_LIMIT = 5000;           // cycles with no handshake
  localparam int PHASE_ITEMS = 120;

  // Receiver stall patterns
  typedef enum int {RX_FREE, RX_RANDOM, RX_SPARSE} rx_mode_e;

  // Belt/counter predictor and store of expected results
  class sorter_check;
    logic [23:0]       min_w, max_w;
    logic [15:0]       modulo;
    logic [7:0]        t_limit;
    bit                running, awaiting;
    logic [15:0]       first_cap;
    logic [7:0]        tally;
    logic [CNT_W-1:0]  total_cnt, std_cnt, over_cnt, under_cnt, defective_cnt;
    bit                sensor_on, passed_on, defect_on;
    out_t              due_results[$];
    int                errors;

    function new();
      min_w = MIN_WIDTH_RST;
      max_w = MAX_WIDTH_RST;
      modulo = MODULO_RST;
      t_limit = TLIMIT_RST;
      running = 0;
      awaiting = 0;
      first_cap = '0;
      tally = '0;
      total_cnt = '0;
      std_cnt = '0;
      over_cnt = '0;
      under_cnt = '0;
      defective_cnt = '0;
      sensor_on = 0;
      passed_on = 0;
      defect_on = 0;
      errors = 0;
    endfunction

    function void set_reg(cfg_reg_e idx, logic [23:0] v);
      case (idx)
        REG_MIN_WIDTH: min_w = v;
        REG_MAX_WIDTH: max_w = v;
        REG_MODULO:    modulo = v[15:0];
        REG_TLIMIT:    t_limit = v[7:0];
      endcase
    endfunction

    // Predicts the result of one accepted item; returns 0 if the item is ignored
    function bit take_item(in_t it);
      out_t    e;
      bit      eff;
      longint  w, q;
      e = '0;
      eff = 1;
      case (it.cmd)
        CMD_EDGE: begin
          if (!running) begin
            eff = 0;
          end else if (!awaiting) begin
            tally = '0;
            awaiting = 1;
            first_cap = it.capture_value;
            sensor_on = 1;
            passed_on = 0;
          end else begin
            // signed width, so a wrapped capture gives a negative (under) item
            w = longint'(it.capture_value) + longint'(tally) * longint'(modulo)
                - longint'(first_cap);
            awaiting = 0;
            if (w >= longint'(min_w) && w <= longint'(max_w)) begin
              std_cnt = std_cnt + 1'b1;
              defect_on = 0;
              e.msg_kind = MSG_STD;
              e.shown_value = 16'(std_cnt);
            end else begin
              if (w > longint'(max_w)) over_cnt = over_cnt + 1'b1;
              else under_cnt = under_cnt + 1'b1;
              defective_cnt = defective_cnt + 1'b1;
              defect_on = 1;
            end
            sensor_on = 0;
            passed_on = 1;
            tally = '0;
            total_cnt = total_cnt + 1'b1;
          end
        end
        CMD_RUNSTOP: begin
          running = !running;
          if (!running) {sensor_on, passed_on, defect_on} = '0;
        end
        CMD_CLEAR: begin
          if (running) eff = 0;
          else total_cnt = '0;
        end
        CMD_SHOWSTD: begin
          e.msg_kind = MSG_STD;
          e.shown_value = 16'(std_cnt);
        end
        CMD_SHOWOVR: begin
          e.msg_kind = MSG_OVER;
          e.shown_value = 16'(over_cnt);
        end
        CMD_SHOWUND: begin
          e.msg_kind = MSG_UNDER;
          e.shown_value = 16'(under_cnt);
        end
        CMD_PERCENT: begin
          e.msg_kind = MSG_PERCENT;
          if (total_cnt == '0) begin
            q = 0;
          end else begin
            q = (longint'(defective_cnt) * PCT_SCALE) / longint'(total_cnt);
          end
          e.shown_value = (q > 65535) ? 16'hFFFF : 16'(q);
        end
        default: begin
          // overflow tick: timeout applies whether or not the belt runs
          if (tally != TALLY_MAX) tally = tally + 1'b1;
          if (tally > t_limit) begin
            tally = '0;
            running = 0;
            {sensor_on, passed_on, defect_on} = '0;
            e.msg_kind = MSG_TIMEOUT;
            e.timed_out = 1'b1;
          end
        end
      endcase
      e.belt_on = running;
      e.sensor_led = sensor_on;
      e.passed_led = passed_on;
      e.defect_led = defect_on;
      due_results.push_back(e);
      return eff;
    endfunction

    function void field_check(string name, int unsigned want, int unsigned got);
      if (want !== got) begin
        $display("%0t tb: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void match_result(out_t got);
      out_t e;
      if (due_results.size() == 0) begin
        $display("%0t tb: result with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      e = due_results.pop_front();
      field_check("belt_on",     e.belt_on,     got.belt_on);
      field_check("sensor_led",  e.sensor_led,  got.sensor_led);
      field_check("passed_led",  e.passed_led,  got.passed_led);
      field_check("defect_led",  e.defect_led,  got.defect_led);
      field_check("msg_kind",    e.msg_kind,    got.msg_kind);
      field_check("shown_value", e.shown_value, got.shown_value);
      field_check("timed_out",   e.timed_out,   got.timed_out);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_t         in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_t        out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  sorter_check sorter;
  int          burst_left = 8;
  int          items_done = 0;
  int          hold_asks = 0;
  int          rx_hold_seen = 0;
  int          rx_hold_left = 0;
  int          rx_tick = 0;
  rx_mode_e    rx_mode = RX_FREE;
  int          quiet_cycles = 0;

  pulse_width_sorter_counter_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Result side: check, then pick the next ready value
  always @(posedge clk) begin
    if (out_valid && out_ready) sorter.match_result(out_data);
    rx_tick <= rx_tick + 1;
    if (rx_tick % 64 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 2));
    if (rx_hold_seen != hold_asks) begin
      rx_hold_seen <= hold_asks;
      rx_hold_left <= HOLD_LEN;
      out_ready <= 1'b0;
    end else if (rx_hold_left != 0) begin
      rx_hold_left <= rx_hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_FREE:   out_ready <= 1'b1;
        RX_RANDOM: out_ready <= 1'($urandom_range(0, 1));
        default:   out_ready <= (rx_tick % 3 == 0);
      endcase
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one item, note it on acceptance, then maybe start a gap
  task automatic offer(in_t x);
    in_valid <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (!in_ready);
    if (sorter.take_item(x)) items_done++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 30);
    end
  endtask

  task automatic offer_cmd(cmd_e c, logic [15:0] cap);
    in_t x;
    x.cmd = c;
    x.capture_value = cap;
    offer(x);
  endtask

  // Stop offering until every expected result is back, then let the block settle
  task automatic drain;
    in_valid <= 1'b0;
    while (sorter.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [23:0] v);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    sorter.set_reg(idx, v);
  endtask

  task automatic configure(logic [23:0] min_v, logic [23:0] max_v,
                           logic [15:0] mod_v, logic [7:0] lim_v);
    write_reg(REG_MIN_WIDTH, min_v);
    write_reg(REG_MAX_WIDTH, max_v);
    write_reg(REG_MODULO, {8'h00, mod_v});
    write_reg(REG_TLIMIT, {16'h0000, lim_v});
    cfg_we <= 1'b0;
  endtask

  task automatic configure_random;
    int unsigned lo;
    lo = $urandom_range(0, 80000);
    configure(24'(lo), 24'(lo + $urandom_range(0, 60000)),
              16'($urandom_range(1, 65535)), 8'($urandom_range(0, 6)));
  endtask

  // Opening edge, overflow ticks, closing edge aimed at a width of interest
  task automatic edge_pair;
    logic [15:0] c1, c2;
    int          k, lim;
    longint      target, c2l;
    if (!sorter.running) offer_cmd(CMD_RUNSTOP, 16'($urandom));
    lim = sorter.t_limit;
    if ($urandom_range(0, lim < 16 ? 9 : 199) == 0) k = lim + 1;
    else k = $urandom_range(0, lim < 3 ? lim : 3);
    c1 = ($urandom_range(0, 1) != 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
    case ($urandom_range(0, 5))
      0:       target = longint'(sorter.min_w);
      1:       target = longint'(sorter.min_w) - 1;
      2:       target = longint'(sorter.max_w);
      3:       target = longint'(sorter.max_w) + 1;
      4:       target = longint'($urandom_range(sorter.min_w, sorter.max_w));
      default: target = -1;
    endcase
    c2l = target + longint'(c1) - longint'(k) * longint'(sorter.modulo);
    if (target >= 0 && c2l >= 0 && c2l <= 65535) c2 = 16'(c2l);
    else c2 = 16'($urandom);
    offer_cmd(CMD_EDGE, c1);
    repeat (k) offer_cmd(CMD_TICK, 16'($urandom));
    offer_cmd(CMD_EDGE, c2);
  endtask

  // Mostly well-formed pairs, the rest buttons, ticks and raw noise
  task automatic run_phase(int n, bit squeeze);
    int   r;
    in_t  x;
    items_done = 0;
    if (squeeze) hold_asks <= hold_asks + 1;
    while (items_done < n) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        edge_pair();
      end else if (r < 70) begin
        offer_cmd(CMD_RUNSTOP, 16'($urandom));
      end else if (r < 82) begin
        offer_cmd(cmd_e'(3'($urandom_range(2, 6))), 16'($urandom));
      end else if (r < 90) begin
        offer_cmd(CMD_TICK, 16'($urandom));
      end else begin
        x.cmd = 3'($urandom);
        x.capture_value = 16'($urandom);
        offer(x);
      end
    end
    drain();
  endtask

  initial begin
    sorter = new();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items at the reset settings
    configure(MIN_WIDTH_RST, MAX_WIDTH_RST, MODULO_RST, TLIMIT_RST);
    offer_cmd(CMD_EDGE, 16'hFFFF);        // edge while stopped
    offer_cmd(CMD_SHOWSTD, 16'h0000);
    offer_cmd(CMD_SHOWOVR, 16'hFFFF);
    offer_cmd(CMD_SHOWUND, 16'h0000);
    offer_cmd(CMD_RUNSTOP, 16'h0000);
    offer_cmd(CMD_EDGE, 16'd0);
    offer_cmd(CMD_EDGE, 16'd40000);       // standard item
    offer_cmd(CMD_EDGE, 16'hFFFF);
    offer_cmd(CMD_TICK, 16'h0000);
    offer_cmd(CMD_EDGE, 16'd0);           // negative width, under
    offer_cmd(CMD_EDGE, 16'd0);
    offer_cmd(CMD_TICK, 16'h0000);
    offer_cmd(CMD_TICK, 16'h0000);
    offer_cmd(CMD_EDGE, 16'hFFFF);        // over
    offer_cmd(CMD_PERCENT, 16'h0000);
    offer_cmd(CMD_CLEAR, 16'h0000);       // ignored while running
    offer_cmd(CMD_EDGE, 16'd1234);
    offer_cmd(CMD_RUNSTOP, 16'h0000);     // stop keeps the pending edge
    offer_cmd(CMD_RUNSTOP, 16'h0000);
    offer_cmd(CMD_EDGE, 16'd31234);       // width exactly at the minimum
    offer_cmd(CMD_TICK, 16'h0000);
    offer_cmd(CMD_TICK, 16'h0000);
    offer_cmd(CMD_TICK, 16'h0000);        // timeout
    offer_cmd(CMD_CLEAR, 16'h0000);
    offer_cmd(CMD_PERCENT, 16'h0000);     // total zero
    drain();

    // Random phases over several settings
    configure_random();
    run_phase(PHASE_ITEMS, 1'b0);
    configure(24'h000000, 24'hFFFFFF, 16'hFFFF, 8'd254);
    run_phase(PHASE_ITEMS, 1'b0);
    configure(24'hFFFFFF, 24'h000000, 16'd1, 8'd0);   // min above max
    run_phase(PHASE_ITEMS, 1'b0);
    configure_random();
    run_phase(PHASE_ITEMS, 1'b1);                      // long result hold-off
    configure(24'd100, 24'd200, 16'd1, 8'd254);
    run_phase(PHASE_ITEMS, 1'b0);

    // Pile up defects, then one item after a clear: percentage saturates
    configure(24'hFFFFFF, 24'h000000, MODULO_RST, 8'd254);
    while (sorter.defective_cnt < 660) begin
      if (!sorter.running) offer_cmd(CMD_RUNSTOP, 16'($urandom));
      offer_cmd(CMD_EDGE, 16'($urandom));
      offer_cmd(CMD_EDGE, 16'($urandom));
    end
    // close any open pair while the belt still runs, so one item follows the clear
    if (!sorter.running) offer_cmd(CMD_RUNSTOP, 16'h0000);
    if (sorter.awaiting) offer_cmd(CMD_EDGE, 16'($urandom));
    offer_cmd(CMD_RUNSTOP, 16'h0000);
    offer_cmd(CMD_CLEAR, 16'h0000);
    offer_cmd(CMD_RUNSTOP, 16'h0000);
    offer_cmd(CMD_EDGE, 16'($urandom));
    offer_cmd(CMD_EDGE, 16'($urandom));
    offer_cmd(CMD_PERCENT, 16'h0000);
    offer_cmd(CMD_SHOWOVR, 16'h0000);
    offer_cmd(CMD_SHOWUND, 16'h0000);
    drain();

    if (sorter.errors == 0 && sorter.due_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/pwsc_pkg.sv
hw/rtl/pwsc_div.sv
hw/rtl/pwsc_datapath.sv
hw/rtl/pwsc_ctrl.sv
hw/rtl/pulse_width_sorter_counter_top.sv
bench/tb.sv
